/* hw/rtl/b64enc_pkg.sv */
package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  // byte count codes for a group
  localparam logic [1:0] GroupOne   = 2'd1;
  localparam logic [1:0] GroupTwo   = 2'd2;
  localparam logic [1:0] GroupThree = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       final_char;
  } out_item_t;

  // one group of up to three bytes, missing bytes already zero
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       last;
  } group_t;

  // queue head channel between queue and back
  typedef struct packed {
    logic   valid;
    group_t group;
  } grp_chan_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] ext;
    ext = {2'b00, v};
    if (v < 6'd26) begin
      return 8'(ext + 8'd65);
    end else if (v < 6'd52) begin
      return 8'(ext + 8'd71);
    end else if (v < 6'd62) begin
      return 8'(ext - 8'd4);
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

/* hw/rtl/b64enc_front.sv */
module b64enc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64enc_pkg::in_item_t in_i,
  output logic                push_o,
  output b64enc_pkg::group_t  push_group_o,
  input  logic                push_ready_i
);
  import b64enc_pkg::*;

  logic [7:0] held_q [2];
  logic [1:0] count_q, count_d;
  logic       accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  always_comb begin
    count_d      = count_q;
    push_o       = 1'b0;
    push_group_o = '{b0: held_q[0], b1: held_q[1], b2: in_i.data_byte,
                     nbytes: GroupThree, last: in_i.end_of_message};
    if (accept) begin
      case (count_q)
        2'd2: begin
          push_o  = 1'b1;
          count_d = 2'd0;
        end
        2'd1: begin
          push_group_o = '{b0: held_q[0], b1: in_i.data_byte, b2: 8'h00,
                           nbytes: GroupTwo, last: 1'b1};
          push_o  = in_i.end_of_message;
          count_d = in_i.end_of_message ? 2'd0 : 2'd2;
        end
        default: begin
          push_group_o = '{b0: in_i.data_byte, b1: 8'h00, b2: 8'h00,
                           nbytes: GroupOne, last: 1'b1};
          push_o  = in_i.end_of_message;
          count_d = in_i.end_of_message ? 2'd0 : 2'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // held bytes need no reset
  always_ff @(posedge clk_i) begin
    if (accept && count_q == 2'd0) begin
      held_q[0] <= in_i.data_byte;
    end
    if (accept && count_q == 2'd1) begin
      held_q[1] <= in_i.data_byte;
    end
  end

endmodule

/* hw/rtl/b64enc_queue.sv */
module b64enc_queue #(
  parameter int unsigned Depth = b64enc_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  b64enc_pkg::group_t    push_group_i,
  output logic                  push_ready_o,
  output b64enc_pkg::grp_chan_t head_o,
  input  logic                  pop_i
);
  import b64enc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   fill_q;
  logic              do_push, do_pop;

  assign push_ready_o = (fill_q != CntW'(Depth));
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & (fill_q != '0);
  assign head_o.valid = (fill_q != '0);
  assign head_o.group = slot_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end else begin
      return PtrW'(p + 1'b1);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        fill_q <= CntW'(fill_q + 1'b1);
      end else if (do_pop && !do_push) begin
        fill_q <= CntW'(fill_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_group_i;
    end
  end

endmodule

/* hw/rtl/b64enc_back.sv */
module b64enc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b64enc_pkg::grp_chan_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output b64enc_pkg::out_item_t out_o
);
  import b64enc_pkg::*;

  group_t     group_q;
  logic       busy_q, busy_d;
  logic [1:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       adv;
  logic [5:0] sym;
  out_item_t  next_char;

  assign adv   = busy_q & (~out_valid_q | out_ready_i);
  assign pop_o = head_i.valid & (~busy_q | (adv & (idx_q == 2'd3)));

  always_comb begin
    case (idx_q)
      2'd0:    sym = group_q.b0[7:2];
      2'd1:    sym = {group_q.b0[1:0], group_q.b1[7:4]};
      2'd2:    sym = {group_q.b1[3:0], group_q.b2[7:6]};
      default: sym = group_q.b2[5:0];
    endcase
    next_char.text_char  = (idx_q <= group_q.nbytes) ? b64_char(sym) : PadChar;
    next_char.final_char = group_q.last & (idx_q == 2'd3);
  end

  always_comb begin
    busy_d = busy_q;
    if (pop_o) begin
      busy_d = 1'b1;
    end else if (adv && idx_q == 2'd3) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (pop_o) begin
        idx_q <= 2'd0;
      end else if (adv) begin
        idx_q <= 2'(idx_q + 1'b1);
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      group_q <= head_i.group;
    end
    if (adv) begin
      out_q <= next_char;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hw/rtl/base64_stream_encoder.sv */
// path: a completed group is written into the queue, then into the back's group
// register; characters then leave one per cycle while out_ready_i is high
// throughput: one byte per cycle in while the queue has room; three bytes make
// four characters, so the single-character output register sets the sustained rate
// reset: asynchronous active low; clears the fill count, queue and output
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64enc_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  b64enc_pkg::in_item_t  in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output b64enc_pkg::out_item_t out_o
);
  import b64enc_pkg::*;

  // front to queue
  logic      push;
  group_t    push_group;
  logic      push_ready;
  // queue to back
  grp_chan_t head;
  logic      pop;

  // front: gathers bytes into groups of three, closes a short group at
  // end of message with zero fill, one transaction per cycle while the queue has room
  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_o       (push),
    .push_group_o (push_group),
    .push_ready_i (push_ready)
  );

  // short group queue lets the byte side keep going while characters drain
  b64enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  // back: walks the four symbols of a group, pads, marks the final character
  // of a message, and holds each character in the output register
  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
